@@ design/text_console_writer_defines.svh @@
// assertion macros shared by the text console writer modules
// expects clk and rst_n in the scope of every use
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, off while in reset
`define TCW_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console writer check failed");

// next-cycle implication, off while in reset
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer check failed");

`endif

@@ design/tcw_pkg.sv @@
// shared constants, types and helper functions of the text console writer
// no dependencies; the design files refer to it by scoped names, the bench files import it
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;

  // field widths
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int TAB_W  = COL_W + 1;

  // cell store
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;

  // reset values
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0E;
  localparam logic [ROW_W-1:0]  RESET_ROW  = (17 < ROWS) ? ROW_W'(17) : ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

  // command and control byte codes
  localparam logic            CMD_PUT  = 1'b0;
  localparam logic            CMD_READ = 1'b1;
  localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR  = 8'd13;

  // classified operations passed from front to back
  localparam int OP_W = 3;
  typedef logic [OP_W-1:0] op_code_t;
  localparam op_code_t OP_READ  = 3'd0;
  localparam op_code_t OP_PRINT = 3'd1;
  localparam op_code_t OP_LF    = 3'd2;
  localparam op_code_t OP_TAB   = 3'd3;
  localparam op_code_t OP_CR    = 3'd4;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    op_code_t          op;
    logic [CHAR_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              in_range;
  } tcw_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tcw_q_status_t;

  // next tab stop after column x, may reach past the last column
  localparam int TAB_STOPS = COLUMNS / TAB_WIDTH + 1;

  function automatic logic [TAB_W-1:0] next_tab(input logic [COL_W-1:0] x);
    logic [TAB_W-1:0] res;
    logic             found;
    res   = '0;
    found = 1'b0;
    for (int k = 1; k <= TAB_STOPS; k++) begin
      if (!found && (k * TAB_WIDTH > int'(x))) begin
        res   = TAB_W'(k * TAB_WIDTH);
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

@@ design/tcw_ifs.sv @@
// valid/ready channel interfaces for the request and result sides
// depends on tcw_pkg for field widths
interface tcw_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [tcw_pkg::CHAR_W-1:0] char_code;
  logic [tcw_pkg::ROW_W-1:0]  cell_row;
  logic [tcw_pkg::COL_W-1:0]  cell_col;

  modport source (output valid, cmd, char_code, cell_row, cell_col, input ready);
  modport sink   (input valid, cmd, char_code, cell_row, cell_col, output ready);
endinterface

interface tcw_out_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::CHAR_W-1:0] read_char;
  logic [tcw_pkg::ATTR_W-1:0] read_attr;
  logic [tcw_pkg::COL_W-1:0]  cursor_col;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic                       scrolled;

  modport source (output valid, read_char, read_attr, cursor_col, cursor_row, scrolled,
                  input ready);
  modport sink   (input valid, read_char, read_attr, cursor_col, cursor_row, scrolled,
                  output ready);
endinterface

@@ design/tcw_front.sv @@
// front end: takes requests, classifies them and range-checks read addresses
// depends on tcw_pkg and tcw_ifs; feeds tcw_queue
module tcw_front (
  tcw_in_if.sink                 in_ch,
  input  tcw_pkg::tcw_q_status_t q_status,
  output logic                   q_push,
  output tcw_pkg::tcw_op_t       q_op
);

  // take a request whenever the queue has room
  assign in_ch.ready = !q_status.full;
  assign q_push      = in_ch.valid && !q_status.full;

  // decode the command and control bytes
  always_comb begin
    q_op.code     = in_ch.char_code;
    q_op.row      = in_ch.cell_row;
    q_op.col      = in_ch.cell_col;
    q_op.in_range = (int'(in_ch.cell_row) < tcw_pkg::ROWS) &&
                    (int'(in_ch.cell_col) < tcw_pkg::COLUMNS);
    if (in_ch.cmd == tcw_pkg::CMD_READ) begin
      q_op.op = tcw_pkg::OP_READ;
    end else begin
      unique case (in_ch.char_code)
        tcw_pkg::CODE_LF:  q_op.op = tcw_pkg::OP_LF;
        tcw_pkg::CODE_TAB: q_op.op = tcw_pkg::OP_TAB;
        tcw_pkg::CODE_CR:  q_op.op = tcw_pkg::OP_CR;
        default:           q_op.op = tcw_pkg::OP_PRINT;
      endcase
    end
  end

endmodule

@@ design/tcw_queue.sv @@
// short queue of classified requests between front and back
// depends on tcw_pkg and the assertion macro header
`include "text_console_writer_defines.svh"

module tcw_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  tcw_pkg::tcw_op_t       push_op,
  input  logic                   pop,
  output tcw_pkg::tcw_op_t       pop_op,
  output tcw_pkg::tcw_q_status_t status
);

  localparam int PTR_W = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(tcw_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(tcw_pkg::QUEUE_DEPTH);

  tcw_pkg::tcw_op_t  entry_r [tcw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign status.full  = (cnt_r == CNT_FULL);
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_op       = entry_r[rp_r];

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_op;
    end
  end

  `TCW_ASSERT(a_q_no_overflow, push, !status.full)
  `TCW_ASSERT(a_q_no_underflow, pop, !status.empty)

endmodule

@@ design/tcw_back.sv @@
// back end: cursor, ring-of-rows cell store, scroll blanking and result register
// depends on tcw_pkg, tcw_ifs and the assertion macro header
`include "text_console_writer_defines.svh"

module tcw_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
  input  tcw_pkg::tcw_q_status_t     q_status,
  input  tcw_pkg::tcw_op_t           q_op,
  output logic                       q_pop,
  tcw_out_if.source                  out_ch
);

  localparam int CHAR_W = tcw_pkg::CHAR_W;
  localparam int ATTR_W = tcw_pkg::ATTR_W;
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int CELL_W = tcw_pkg::CELL_W;
  localparam int TAB_W  = tcw_pkg::TAB_W;

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(tcw_pkg::COLUMNS);
  localparam logic [TAB_W-1:0]  COL_END   = TAB_W'(tcw_pkg::COLUMNS);

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RDATA = 2'd2;
  localparam logic [1:0] ST_BLANK = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  cur_x_r, cur_x_nxt;
  logic [ROW_W-1:0]  cur_y_r, cur_y_nxt;
  logic [ROW_W-1:0]  base_r, base_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] blank_last_r, blank_last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [ATTR_W-1:0] out_attr_r, out_attr_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              out_scr_r, out_scr_nxt;
  logic              out_load;

  logic [CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
  logic [CELL_W-1:0] mem_rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              out_free, go, adv, is_last_row, scroll_go, is_put;
  logic [COL_W-1:0]  nx;
  logic [ROW_W-1:0]  ny;
  logic [TAB_W-1:0]  tab_pos, inc_x;
  logic [ADDR_W-1:0] base_row_addr;

  // store address of a screen row and column through the row ring
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] base);
    logic [ROW_W:0] phys;
    phys = {1'b0, row} + {1'b0, base};
    if (int'(phys) >= tcw_pkg::ROWS) begin
      phys = phys - (ROW_W + 1)'(tcw_pkg::ROWS);
    end
    return ADDR_W'(phys) * ROW_SPAN + ADDR_W'(col);
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign go       = (st_r == ST_IDLE) && !q_status.empty && out_free;
  assign q_pop    = go;

  // cursor movement for the request at the head of the queue
  assign tab_pos       = tcw_pkg::next_tab(cur_x_r);
  assign inc_x         = {1'b0, cur_x_r} + 1'b1;
  assign is_last_row   = (cur_y_r == tcw_pkg::LAST_ROW);
  assign is_put        = (q_op.op != tcw_pkg::OP_READ);
  assign base_row_addr = ADDR_W'(base_r) * ROW_SPAN;

  always_comb begin
    nx  = cur_x_r;
    adv = 1'b0;
    unique case (q_op.op)
      tcw_pkg::OP_LF: begin
        nx  = '0;
        adv = 1'b1;
      end
      tcw_pkg::OP_TAB: begin
        if (tab_pos >= COL_END) begin
          nx  = '0;
          adv = 1'b1;
        end else begin
          nx = tab_pos[COL_W-1:0];
        end
      end
      tcw_pkg::OP_CR: begin
        nx = '0;
      end
      tcw_pkg::OP_PRINT: begin
        if (inc_x >= COL_END) begin
          nx  = '0;
          adv = 1'b1;
        end else begin
          nx = inc_x[COL_W-1:0];
        end
      end
      default: begin
        nx  = cur_x_r;
        adv = 1'b0;
      end
    endcase
  end

  assign scroll_go = go && is_put && adv && is_last_row;
  assign ny        = (adv && !is_last_row) ? cur_y_r + 1'b1 : cur_y_r;

  // cell store ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = tcw_pkg::BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = cell_addr(q_op.row, q_op.col, base_r);
    if ((st_r == ST_CLEAR) || (st_r == ST_BLANK)) begin
      mem_we = 1'b1;
    end else if (go && (q_op.op == tcw_pkg::OP_PRINT)) begin
      mem_we    = 1'b1;
      mem_waddr = cell_addr(cur_y_r, cur_x_r, base_r);
      mem_wdata = {attr_r, q_op.code};
    end
    if (go && (q_op.op == tcw_pkg::OP_READ) && q_op.in_range) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // sequencer
  always_comb begin
    st_nxt         = st_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    blank_last_nxt = blank_last_r;
    out_load       = 1'b0;
    out_char_nxt   = '0;
    out_attr_nxt   = '0;
    out_col_nxt    = cur_x_r;
    out_row_nxt    = cur_y_r;
    out_scr_nxt    = 1'b0;
    unique case (st_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ADDR_LAST) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (go) begin
          cur_x_nxt = nx;
          cur_y_nxt = ny;
          if ((q_op.op == tcw_pkg::OP_READ) && q_op.in_range) begin
            st_nxt = ST_RDATA;
          end else if (scroll_go) begin
            // old top row becomes the new bottom row
            st_nxt         = ST_BLANK;
            base_nxt       = (base_r == tcw_pkg::LAST_ROW) ? '0 : base_r + 1'b1;
            cnt_nxt        = base_row_addr;
            blank_last_nxt = base_row_addr + ROW_SPAN - 1'b1;
          end else begin
            out_load    = 1'b1;
            out_col_nxt = nx;
            out_row_nxt = ny;
          end
        end
      end
      ST_RDATA: begin
        out_load     = 1'b1;
        out_char_nxt = mem_rdata_r[CHAR_W-1:0];
        out_attr_nxt = mem_rdata_r[CELL_W-1:CHAR_W];
        st_nxt       = ST_IDLE;
      end
      ST_BLANK: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == blank_last_r) begin
          out_load    = 1'b1;
          out_scr_nxt = 1'b1;
          st_nxt      = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  // result register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      attr_r      <= tcw_pkg::ATTR_RESET;
      cur_x_r     <= '0;
      cur_y_r     <= tcw_pkg::RESET_ROW;
      base_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    blank_last_r <= blank_last_nxt;
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_attr_r <= out_attr_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_scr_r  <= out_scr_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_char  = out_char_r;
  assign out_ch.read_attr  = out_attr_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.scrolled   = out_scr_r;

  `TCW_ASSERT(a_cursor_on_screen, 1'b1,
              (int'(cur_x_r) < tcw_pkg::COLUMNS) && (int'(cur_y_r) < tcw_pkg::ROWS))
  `TCW_ASSERT(a_load_into_free_slot, out_load, out_free)
  `TCW_ASSERT(a_ring_moves_on_scroll, base_r != $past(base_r), $past(scroll_go))
  `TCW_ASSERT_NEXT(a_scroll_blanks_row, scroll_go, st_r == ST_BLANK)

endmodule

@@ design/text_console_writer.sv @@
// Character-cell text console, 80 columns by 25 rows of char/attribute cells. After reset
// a clearing pass writes the blank cell (char 0, attribute 0x07) into all 2000 cells, one
// per cycle. No request is carried out during that pass, though up to two requests
// are taken into the queue and wait there; attribute writes are taken at any time.
// A front end classifies each request into a two-entry queue, and the back
// end carries it out: a put of a control or printable byte is done in the idle state, an
// in-range read also passes the read-data state because of the registered store read
// port. The screen is kept as a ring of rows, so a scroll moves the top-row pointer and
// blanks the new bottom row one cell per cycle; a put that scrolls ends with that
// blanking sweep. Each request gives exactly one result, held in an output register.
// depends on tcw_pkg, tcw_ifs, tcw_front, tcw_queue and tcw_back
module text_console_writer (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_in_if.sink                     in_ch,
  tcw_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);

  tcw_pkg::tcw_q_status_t q_status;
  tcw_pkg::tcw_op_t       push_op, pop_op;
  logic                   q_push, q_pop;

  // classify incoming requests
  tcw_front u_front (
    .in_ch    (in_ch),
    .q_status (q_status),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  // decouple front from back
  tcw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .status  (q_status)
  );

  // execute against cursor and cell store
  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .q_op      (pop_op),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

@@ bench/tcw_checker.sv @@
// scoreboard for the text console writer: tracks screen, cursor and attribute
// from accepted requests and compares every result against the oldest expectation
// depends on tcw_pkg and the channel interfaces in tcw_ifs
module tcw_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_in_if                          in_ch,
  tcw_out_if                         out_ch,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         results_seen,
  output int                         pending,
  output int                         scroll_count
);
  import tcw_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] rd_char;
    logic [ATTR_W-1:0] rd_attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scrolled;
  } console_result_t;

  // shadow copy of the console
  logic [CELL_W-1:0] screen [CELL_COUNT];
  int unsigned       cur_x;
  int unsigned       cur_y;
  logic [ATTR_W-1:0] attr;
  console_result_t   console_q[$];
  int                fails;
  int                checked;
  int                scrolls;

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
  endfunction

  // carry out one request on the shadow console and return its result
  function automatic console_result_t apply_request(input logic cmd,
                                                    input logic [CHAR_W-1:0] code,
                                                    input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
    console_result_t   r;
    int unsigned       shift;
    logic [CELL_W-1:0] cell_word;
    r = '0;
    if (cmd == CMD_READ) begin
      // out-of-range reads return an empty cell
      if (row < ROWS && col < COLUMNS) begin
        cell_word = screen[int'(row) * COLUMNS + int'(col)];
        r.rd_char = cell_word[CHAR_W-1:0];
        r.rd_attr = cell_word[CELL_W-1:CHAR_W];
      end
    end else begin
      if (code == CODE_LF) begin
        cur_x = 0;
        cur_y++;
      end else if (code == CODE_TAB) begin
        cur_x = cur_x + TAB_WIDTH - (cur_x % TAB_WIDTH);
        // tab past the last column wraps to the next row
        if (cur_x >= COLUMNS) begin
          cur_x = 0;
          cur_y++;
        end
      end else if (code == CODE_CR) begin
        cur_x = 0;
      end else begin
        screen[cur_y * COLUMNS + cur_x] = {attr, code};
        cur_x++;
        if (cur_x >= COLUMNS) begin
          cur_x = 0;
          cur_y++;
        end
      end
      // scroll up by the overshoot and blank the freed rows
      if (cur_y > ROWS - 1) begin
        shift = (cur_y - (ROWS - 1)) * COLUMNS;
        for (int i = 0; i < CELL_COUNT; i++) begin
          if (i + shift < CELL_COUNT) screen[i] = screen[i + shift];
          else screen[i] = BLANK_CELL;
        end
        cur_y      = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end
    r.col = cur_x[COL_W-1:0];
    r.row = cur_y[ROW_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // track requests, attribute writes and results at every edge
  always @(posedge clk) begin
    console_result_t r;
    console_result_t want;
    if (!rst_n) begin
      blank_screen();
      cur_x   = 0;
      cur_y   = RESET_ROW;
      attr    = ATTR_RESET;
      fails   = 0;
      checked = 0;
      scrolls = 0;
      console_q.delete();
    end else begin
      if (cfg_we) attr = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        r = apply_request(in_ch.cmd, in_ch.char_code, in_ch.cell_row, in_ch.cell_col);
        if (r.scrolled) scrolls++;
        console_q.push_back(r);
      end
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (console_q.size() == 0) begin
          fails++;
          $display("%0t: result with no request pending, got char %0d attr %0d col %0d row %0d",
                   $time, out_ch.read_char, out_ch.read_attr, out_ch.cursor_col,
                   out_ch.cursor_row);
        end else begin
          want = console_q.pop_front();
          check_field("read_char", 16'(want.rd_char), 16'(out_ch.read_char));
          check_field("read_attr", 16'(want.rd_attr), 16'(out_ch.read_attr));
          check_field("cursor_col", 16'(want.col), 16'(out_ch.cursor_col));
          check_field("cursor_row", 16'(want.row), 16'(out_ch.cursor_row));
          check_field("scrolled", 16'(want.scrolled), 16'(out_ch.scrolled));
        end
      end
    end
    fail_count   <= fails;
    results_seen <= checked;
    pending      <= console_q.size();
    scroll_count <= scrolls;
  end

endmodule

@@ bench/testbench.sv @@
// top of the text console writer bench: clock, reset, request and result drivers,
// attribute writes and the verdict
// depends on tcw_pkg, tcw_ifs, text_console_writer and tcw_checker
module testbench;
  import tcw_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  int fail_count;
  int results_seen;
  int pending;
  int scroll_count;
  int sent;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_toggle;

  text_console_writer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tcw_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .pending      (pending),
    .scroll_count (scroll_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #8000000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random back-pressure plus one long hold on request
  initial begin
    bit last_toggle;
    int hold_left;
    last_toggle  = 1'b0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != last_toggle) begin
        last_toggle = hold_toggle;
        hold_left   = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(rx_idle_on && $urandom_range(0, 99) < 22);
      end
    end
  end

  // offer one request and wait for it to be taken
  task automatic send_request(input logic cmd, input logic [CHAR_W-1:0] code,
                              input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    while (tx_idle_on && $urandom_range(0, 99) < 22) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.char_code <= code;
    in_ch.cell_row  <= row;
    in_ch.cell_col  <= col;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // put with junk in the unused cell fields
  task automatic put_char(input logic [CHAR_W-1:0] code);
    send_request(CMD_PUT, code, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
  endtask

  task automatic read_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    send_request(CMD_READ, CHAR_W'($urandom_range(0, 255)), row, col);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen != sent) @(posedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly printable text, with control bytes and reads mixed in
  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      if ($urandom_range(0, 4) == 0)
        read_cell(ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
      else
        read_cell(ROW_W'($urandom_range(0, ROWS - 1)), COL_W'($urandom_range(0, COLUMNS - 1)));
    end else if (pick < 32) begin
      put_char(CODE_LF);
    end else if (pick < 40) begin
      put_char(CODE_TAB);
    end else if (pick < 45) begin
      put_char(CODE_CR);
    end else begin
      put_char(CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [ATTR_W-1:0] phase_attr;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_PUT;
    in_ch.char_code = '0;
    in_ch.cell_row  = '0;
    in_ch.cell_col  = '0;
    tx_idle_on      = 1'b0;
    rx_idle_on      = 1'b0;
    hold_toggle     = 1'b0;
    sent            = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corner reads on the blank screen, including out of range
    read_cell('0, '0);
    read_cell(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    read_cell(5'd31, 7'd127);
    read_cell('0, COL_W'(COLUMNS));
    // extreme bytes at the reset attribute, then read one back
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h41);
    read_cell(RESET_ROW, COL_W'(1));
    // carriage return, then tabs until one runs past the last column
    put_char(CODE_CR);
    repeat (10) put_char(CODE_TAB);
    // line feeds down past the bottom row to force a scroll
    repeat (7) put_char(CODE_LF);
    read_cell(ROW_W'(RESET_ROW - 1'b1), COL_W'(1));
    wait_drained();

    // random phases, each under its own attribute
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: phase_attr = 8'h00;
        1: phase_attr = 8'hFF;
        default: phase_attr = ATTR_W'($urandom_range(0, 255));
      endcase
      write_attr(phase_attr);
      tx_idle_on = (phase != 0);
      rx_idle_on = (phase != 0);
      for (int n = 0; n < 250; n++) begin
        if (phase == 2 && n == 40) hold_toggle <= ~hold_toggle;
        if (phase == 3 && n == 125) wait_drained();
        random_request();
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("%0d requests checked against %0d results, %0d of them scrolled the screen",
             sent, results_seen, scroll_count);
    $display("attributes: reset value, 0x00, 0xFF and two random bytes; "
             , "one long result hold and one full drain mid-stream");
    if (fail_count == 0 && pending == 0 && results_seen == sent) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
